// ===== src/triple_key_membership_set_defines.svh =====
// Assertion macros for the triple-key membership set.
`ifndef TRIPLE_KEY_MEMBERSHIP_SET_DEFINES_SVH
`define TRIPLE_KEY_MEMBERSHIP_SET_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TKMS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TKMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tkms_pkg.sv =====
// Shared constants and types of the triple-key membership set.
package tkms_pkg;

    localparam int MAP_W   = 14;
    localparam int EVENT_W = 14;
    localparam int PAGE_W  = 7;
    localparam int KEY_W   = MAP_W + EVENT_W + PAGE_W;
    localparam int OP_W    = 2;

    localparam int S_TDATA_W = ((KEY_W + 7) / 8) * 8;
    localparam int S_TUSER_W = OP_W + 1;
    localparam int M_TDATA_W = 8;

    localparam logic [OP_W-1:0] OP_MARK  = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic table_full;
        logic removed;
        logic found;
    } result_t;

endpackage

// ===== src/tkms_key_ram.sv =====
// Key storage: one write port, one registered read port.
module tkms_key_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [tkms_pkg::KEY_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [tkms_pkg::KEY_W-1:0] rd_data
);

    logic [tkms_pkg::KEY_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/tkms_seq.sv =====
// Sequencer: scans stored keys through one comparator, then inserts or deletes; clear empties the table.
module tkms_seq #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int CNT_W  = 7
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tkms_pkg::OP_W-1:0]  op,
    input  logic                       remove_request,
    input  logic [tkms_pkg::KEY_W-1:0] key,
    output logic                       idle,
    output logic                       done,
    output tkms_pkg::result_t          result,
    output logic                       rd_en,
    output logic [ADDR_W-1:0]          rd_addr,
    input  logic [tkms_pkg::KEY_W-1:0] rd_data,
    output logic                       wr_en,
    output logic [ADDR_W-1:0]          wr_addr,
    output logic [tkms_pkg::KEY_W-1:0] wr_data
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_CMP  = 5'b00100,
        ST_MVRD = 5'b01000,
        ST_MVWR = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    logic [ADDR_W-1:0]          idx_reg, idx_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [tkms_pkg::KEY_W-1:0] key_reg, key_next;
    logic [tkms_pkg::OP_W-1:0]  op_reg, op_next;
    logic                       rm_reg, rm_next;

    logic [CNT_W-1:0]  count_m1;
    logic [ADDR_W-1:0] last_idx;
    logic              full;
    logic              hit;
    logic              at_last;

    assign count_m1 = count_reg - CNT_W'(1);
    assign last_idx = count_m1[ADDR_W-1:0];
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign hit      = (rd_data == key_reg);
    assign at_last  = (idx_reg == last_idx);
    assign idle     = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        key_next   = key_reg;
        op_next    = op_reg;
        rm_next    = rm_reg;
        done       = 1'b0;
        result     = '0;
        rd_en      = 1'b0;
        rd_addr    = idx_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = key_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    key_next = key;
                    op_next  = op;
                    rm_next  = remove_request;
                    idx_next = '0;
                    if (op == tkms_pkg::OP_MARK || op == tkms_pkg::OP_QUERY)
                    begin
                        if (count_reg == '0)
                        begin
                            // Empty table: a mark goes straight into slot zero
                            done = 1'b1;
                            if (op == tkms_pkg::OP_MARK)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = '0;
                                wr_data    = key;
                                count_next = CNT_W'(1);
                            end
                        end
                        else
                        begin
                            state_next = ST_READ;
                        end
                    end
                    else
                    begin
                        done = 1'b1;
                        if (op == tkms_pkg::OP_CLEAR)
                        begin
                            count_next = '0;
                        end
                    end
                end
            end

            ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_CMP;
            end

            ST_CMP:
            begin
                if (hit)
                begin
                    if (op_reg == tkms_pkg::OP_MARK && rm_reg && !at_last)
                    begin
                        // Fill the hole with the last entry
                        state_next = ST_MVRD;
                    end
                    else
                    begin
                        done         = 1'b1;
                        result.found = 1'b1;
                        state_next   = ST_IDLE;
                        if (op_reg == tkms_pkg::OP_MARK && rm_reg)
                        begin
                            result.removed = 1'b1;
                            count_next     = count_m1;
                        end
                    end
                end
                else if (at_last)
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                    if (op_reg == tkms_pkg::OP_MARK)
                    begin
                        if (full)
                        begin
                            result.table_full = 1'b1;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[ADDR_W-1:0];
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
                else
                begin
                    idx_next   = idx_reg + ADDR_W'(1);
                    state_next = ST_READ;
                end
            end

            ST_MVRD:
            begin
                rd_en      = 1'b1;
                rd_addr    = last_idx;
                state_next = ST_MVWR;
            end

            ST_MVWR:
            begin
                wr_en          = 1'b1;
                wr_data        = rd_data;
                count_next     = count_m1;
                done           = 1'b1;
                result.found   = 1'b1;
                result.removed = 1'b1;
                state_next     = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        key_reg <= key_next;
        op_reg  <= op_next;
        rm_reg  <= rm_next;
    end

endmodule

// ===== src/triple_key_membership_set.sv =====
// Clear, an unused op or an empty table needs no key scan; a lookup reads and compares the
// stored keys one at a time, and a delete from mid-table then moves the last key into the
// hole. The single key memory read port and comparator set how long an item takes.
// One item in flight; the next is accepted the cycle after its result is taken.
// Reset (rst_n, asynchronous, active low) empties the table; no clearing pass is needed.
// Top level of the triple-key membership set.
`include "triple_key_membership_set_defines.svh"

module triple_key_membership_set #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // map_id[13:0], event_id[27:14], page_id[34:28], zero pad
    input  logic [tkms_pkg::S_TDATA_W-1:0] s_tdata,
    // op[1:0], remove_request[2]
    input  logic [tkms_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // found[0], removed[1], table_full[2], zero pad
    output logic [tkms_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    logic                       seq_idle;
    logic                       seq_done;
    tkms_pkg::result_t          seq_result;
    logic                       start;
    logic                       rd_en;
    logic [ADDR_W-1:0]          rd_addr;
    logic [tkms_pkg::KEY_W-1:0] rd_data;
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [tkms_pkg::KEY_W-1:0] wr_data;

    logic                       m_tvalid_reg, m_tvalid_next;
    tkms_pkg::result_t          res_reg, res_next;

    assign s_tready = seq_idle && !m_tvalid_reg;
    assign start    = s_tvalid && s_tready;

    tkms_seq #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .op             (s_tuser[tkms_pkg::OP_W-1:0]),
        .remove_request (s_tuser[tkms_pkg::OP_W]),
        .key            (s_tdata[tkms_pkg::KEY_W-1:0]),
        .idle           (seq_idle),
        .done           (seq_done),
        .result         (seq_result),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data)
    );

    tkms_key_ram #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Hold the result until the item is taken
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        res_next      = res_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (seq_done)
        begin
            m_tvalid_next = 1'b1;
            res_next      = seq_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(tkms_pkg::M_TDATA_W - 3){1'b0}}, res_reg};

    `TKMS_ASSERT_NOW(a_ready_excl, s_tready, !m_tvalid, "input ready while result pending")
    `TKMS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
        "ready right after an accepted item")
    `TKMS_ASSERT_NOW(a_removed_found, m_tvalid && m_tdata[1], m_tdata[0],
        "removed without found")
    `TKMS_ASSERT_NOW(a_full_excl, m_tvalid && m_tdata[2], !m_tdata[0] && !m_tdata[1],
        "table_full together with found or removed")

endmodule
